/* hdl/pqp_pkg.sv */
`default_nettype none
package pqp_pkg;

   localparam int COORD_BITS = 20;
   localparam int FRAC_BITS  = 16;
   localparam int CNT_BITS   = 16;

   // Curve coefficients and line differences.
   localparam int OW = COORD_BITS + 2;
   // Products and the discriminant radicand.
   localparam int PW = 2 * OW;
   // Square root of the radicand.
   localparam int SW = OW;
   // Signed root numerator and denominator.
   localparam int NW = OW + 2;
   // Magnitude of a normalized numerator or denominator.
   localparam int UW = OW + 1;
   // Curve parameter t in [0, 1], fixed point.
   localparam int TW = FRAC_BITS + 1;
   // Weighted x products.
   localparam int XW = TW + COORD_BITS + 1;
   localparam int QDEPTH = 2;

   localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [TW-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [2:0] {
      KIND_ZERO,
      KIND_ONE,
      KIND_LINE,
      KIND_LIN,
      KIND_QUAD
   } kind_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] ctrl_x;
      logic signed [COORD_BITS-1:0] ctrl_y;
      logic signed [COORD_BITS-1:0] stop_x;
      logic signed [COORD_BITS-1:0] stop_y;
      logic                         straight;
      logic                         last_edge;
   } req_type;

   typedef struct packed {
      logic                inside_res;
      logic [CNT_BITS-1:0] crossings;
   } rsp_type;

   // One classified edge as it waits between the front and the back.
   typedef struct packed {
      kind_type                     kind;
      logic                         last;
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] sx;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] ex;
      logic signed [OW-1:0]         op0;
      logic signed [OW-1:0]         op1;
      logic signed [OW-1:0]         op2;
      logic signed [OW-1:0]         op3;
   } edge_type;

   function automatic logic signed [OW-1:0] ext_op(input logic signed [COORD_BITS-1:0] v);
      return {{(OW-COORD_BITS){v[COORD_BITS-1]}}, v};
   endfunction

endpackage
`default_nettype wire

/* hdl/pqp_req_if.sv */
`default_nettype none
interface pqp_req_if;
   import pqp_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/pqp_rsp_if.sv */
`default_nettype none
interface pqp_rsp_if;
   import pqp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/pqp_front.sv */
`default_nettype none
module pqp_front (
   pqp_req_if.sink         req_chan,
   input  logic            fifo_full,
   output logic            fifo_push,
   output pqp_pkg::edge_type fifo_data
);
   import pqp_pkg::*;

   logic signed [COORD_BITS-1:0] px, py, sx, sy, cx, cy, ex, ey, xmax, ymin, ymax;
   logic signed [OW-1:0] coef_a, coef_b;

   assign req_chan.ready = !fifo_full;
   assign fifo_push      = req_chan.valid && !fifo_full;

   always_comb begin
      px = req_chan.data.point_x;
      py = req_chan.data.point_y;
      sx = req_chan.data.start_x;
      sy = req_chan.data.start_y;
      cx = req_chan.data.ctrl_x;
      cy = req_chan.data.ctrl_y;
      ex = req_chan.data.stop_x;
      ey = req_chan.data.stop_y;
      ymin = (sy < ey) ? sy : ey;
      ymax = (sy < ey) ? ey : sy;
      xmax = (sx > ex) ? sx : ex;
      coef_a = ext_op(sy) - (ext_op(cy) <<< 1) + ext_op(ey);
      coef_b = (ext_op(cy) - ext_op(sy)) <<< 1;

      fifo_data.last = req_chan.data.last_edge;
      fifo_data.px   = px;
      fifo_data.sx   = sx;
      fifo_data.cx   = cx;
      fifo_data.ex   = ex;
      fifo_data.op0  = '0;
      fifo_data.op1  = '0;
      fifo_data.op2  = '0;
      fifo_data.op3  = '0;
      fifo_data.kind = KIND_ZERO;

      // A ray through the stop vertex is counted by the next edge only.
      if ((py == ey) && (px < ex)) begin
         fifo_data.kind = KIND_ZERO;
      end else if (req_chan.data.straight) begin
         if ((py < ymin) || (py > ymax)) begin
            fifo_data.kind = KIND_ZERO;
         end else if (sy == ey) begin
            fifo_data.kind = (xmax >= px) ? KIND_ONE : KIND_ZERO;
         end else begin
            fifo_data.kind = KIND_LINE;
            fifo_data.op0  = ext_op(sx) - ext_op(px);
            fifo_data.op1  = ext_op(ey) - ext_op(sy);
            fifo_data.op2  = ext_op(ex) - ext_op(sx);
            fifo_data.op3  = ext_op(py) - ext_op(sy);
         end
      end else begin
         fifo_data.op0 = coef_a;
         fifo_data.op1 = coef_b;
         fifo_data.op2 = ext_op(sy) - ext_op(py);
         if (coef_a != '0) begin
            fifo_data.kind = KIND_QUAD;
         end else if (coef_b != '0) begin
            fifo_data.kind = KIND_LIN;
         end else begin
            fifo_data.kind = KIND_ZERO;
         end
      end
   end
endmodule
`default_nettype wire

/* hdl/pqp_fifo.sv */
`default_nettype none
module pqp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pqp_pkg::edge_type wr_data,
   input  logic              pop,
   output pqp_pkg::edge_type rd_data,
   output logic              full,
   output logic              empty
);
   import pqp_pkg::*;

   localparam int PTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CNT_W    = $clog2(QDEPTH + 1);

   edge_type            entry_ff [QDEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full    = (count_ff == CNT_W'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end
endmodule
`default_nettype wire

/* hdl/pqp_isqrt.sv */
`default_nettype none
module pqp_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pqp_pkg::PW-1:0]     radicand,
   output logic                       done,
   output logic [pqp_pkg::SW-1:0]     root
);
   import pqp_pkg::*;

   // Two radicand bits are retired per cycle.
   localparam int ITERS = PW / 2;
   localparam int CW_B  = $clog2(ITERS + 1);

   logic            busy_ff, busy_in, done_ff, done_in;
   logic [CW_B-1:0] cnt_ff, cnt_in;
   logic [PW-1:0]   rad_ff, rad_in;
   logic [SW+1:0]   rem_ff, rem_in, rem_sh, trial;
   logic [SW-1:0]   root_ff, root_in;

   assign done = done_ff;
   assign root = root_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[SW-1:0], rad_ff[PW-1 -: 2]};
      trial   = {root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW_B'(ITERS);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[SW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[SW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW_B'(1);
         if (cnt_ff == CW_B'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end
endmodule
`default_nettype wire

/* hdl/pqp_div.sv */
`default_nettype none
module pqp_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [pqp_pkg::UW-1:0] num,
   input  logic [pqp_pkg::UW-1:0] den,
   output logic                   done,
   output logic [pqp_pkg::TW-1:0] quo
);
   import pqp_pkg::*;

   // Restoring division of num * 2^FRAC_BITS by den, with num <= den,
   // one quotient bit per cycle.
   localparam int CW_B = $clog2(TW + 1);

   logic            busy_ff, busy_in, done_ff, done_in, ge;
   logic [CW_B-1:0] cnt_ff, cnt_in;
   logic [UW:0]     rem_ff, rem_in, rem_sub;
   logic [UW-1:0]   den_ff, den_in;
   logic [TW-1:0]   quo_ff, quo_in;

   assign done = done_ff;
   assign quo  = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      ge      = (rem_ff >= {1'b0, den_ff});
      rem_sub = ge ? rem_ff - {1'b0, den_ff} : rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW_B'(TW);
         rem_in  = {1'b0, num};
         den_in  = den;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = {rem_sub[UW-1:0], 1'b0};
         quo_in = {quo_ff[TW-2:0], ge};
         cnt_in = cnt_ff - CW_B'(1);
         if (cnt_ff == CW_B'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end
endmodule
`default_nettype wire

/* hdl/pqp_back.sv */
`default_nettype none
module pqp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              fifo_empty,
   input  pqp_pkg::edge_type fifo_data,
   output logic              fifo_pop,
   pqp_rsp_if.source         rsp_chan
);
   import pqp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LMUL, ST_LCMP, ST_QMUL, ST_DISC, ST_SQRT, ST_ROOTS,
      ST_DSTART, ST_DWAIT, ST_EW, ST_EX, ST_ES, ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   edge_type             ent_ff, ent_in;
   logic [1:0]           hits_ff, hits_in;
   logic [CNT_BITS-1:0]  total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic signed [PW-1:0] prod0_ff, prod0_in, prod1_ff, prod1_in;
   logic                 sel_ff, sel_in, v0_ff, v0_in, v1_ff, v1_in;
   logic [UW-1:0]        n0_ff, n0_in, n1_ff, n1_in, dn_ff, dn_in;
   logic [TW-1:0]        w0_ff, w0_in, w1_ff, w1_in, w2_ff, w2_in;
   logic signed [XW-1:0] x0_ff, x0_in, x1_ff, x1_in, x2_ff, x2_in;

   logic                 sq_start, sq_done, dv_start, dv_done0, dv_done1, stall, hit;
   logic [SW-1:0]        sq_root;
   logic [TW-1:0]        q0, q1, t_sel, dt;
   logic [2*TW-1:0]      pw0, pw1, pw2;
   logic signed [PW:0]   lhs;
   logic signed [PW+2:0] disc;
   logic signed [NW-1:0] den_s, num0_s, num1_s, den_a, num0_a, num1_a;
   logic signed [XW+1:0] sum, rhs;
   logic [CNT_BITS:0]    tot_sum;
   logic [CNT_BITS-1:0]  tot_new;

   pqp_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (disc[PW-1:0]),
      .done     (sq_done),
      .root     (sq_root)
   );

   pqp_div u_div0 (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (n0_ff),
      .den   (dn_ff),
      .done  (dv_done0),
      .quo   (q0)
   );

   pqp_div u_div1 (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (n1_ff),
      .den   (dn_ff),
      .done  (dv_done1),
      .quo   (q1)
   );

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      hits_in      = hits_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      prod0_in     = prod0_ff;
      prod1_in     = prod1_ff;
      sel_in       = sel_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      n0_in        = n0_ff;
      n1_in        = n1_ff;
      dn_in        = dn_ff;
      w0_in        = w0_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      fifo_pop     = 1'b0;
      sq_start     = 1'b0;
      dv_start     = 1'b0;

      lhs  = (PW+1)'(prod0_ff) + (PW+1)'(prod1_ff);
      disc = (PW+3)'(prod0_ff) - ((PW+3)'(prod1_ff) <<< 2);

      // Root numerators and denominator for the current curve.
      if (ent_ff.kind == KIND_LIN) begin
         den_s  = NW'($signed(ent_ff.op1));
         num0_s = -NW'($signed(ent_ff.op2));
         num1_s = '0;
      end else begin
         den_s  = NW'($signed(ent_ff.op0)) <<< 1;
         num0_s = -NW'($signed(ent_ff.op1)) + $signed({{(NW-SW){1'b0}}, sq_root});
         num1_s = -NW'($signed(ent_ff.op1)) - $signed({{(NW-SW){1'b0}}, sq_root});
      end
      den_a  = den_s[NW-1] ? -den_s : den_s;
      num0_a = den_s[NW-1] ? -num0_s : num0_s;
      num1_a = den_s[NW-1] ? -num1_s : num1_s;

      t_sel = sel_ff ? q1 : q0;
      dt    = T_ONE - t_sel;
      pw0   = (2*TW)'(dt) * (2*TW)'(dt);
      pw1   = (2*TW)'(dt) * (2*TW)'(t_sel);
      pw2   = (2*TW)'(t_sel) * (2*TW)'(t_sel);

      sum = (XW+2)'(x0_ff) + (XW+2)'(x1_ff) + (XW+2)'(x2_ff);
      rhs = (XW+2)'($signed(ent_ff.px)) <<< FRAC_BITS;
      hit = (sel_ff ? v1_ff : v0_ff) && (sum >= rhs);

      tot_sum = {1'b0, total_ff} + (CNT_BITS+1)'(hits_ff);
      tot_new = (tot_sum > (CNT_BITS+1)'(CNT_MAX)) ? CNT_MAX : tot_sum[CNT_BITS-1:0];
      stall   = ent_ff.last && rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               fifo_pop = 1'b1;
               ent_in   = fifo_data;
               hits_in  = 2'd0;
               case (fifo_data.kind)
                  KIND_ONE: begin
                     hits_in  = 2'd1;
                     state_in = ST_DONE;
                  end
                  KIND_LINE: state_in = ST_LMUL;
                  KIND_LIN:  state_in = ST_ROOTS;
                  KIND_QUAD: state_in = ST_QMUL;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_LMUL: begin
            prod0_in = PW'($signed(ent_ff.op0)) * PW'($signed(ent_ff.op1));
            prod1_in = PW'($signed(ent_ff.op2)) * PW'($signed(ent_ff.op3));
            state_in = ST_LCMP;
         end
         ST_LCMP: begin
            if ($signed(ent_ff.op1) > 0) begin
               hits_in = (lhs >= 0) ? 2'd1 : 2'd0;
            end else begin
               hits_in = (lhs <= 0) ? 2'd1 : 2'd0;
            end
            state_in = ST_DONE;
         end
         ST_QMUL: begin
            prod0_in = PW'($signed(ent_ff.op1)) * PW'($signed(ent_ff.op1));
            prod1_in = PW'($signed(ent_ff.op0)) * PW'($signed(ent_ff.op2));
            state_in = ST_DISC;
         end
         ST_DISC: begin
            if (disc[PW+2]) begin
               state_in = ST_DONE;
            end else begin
               sq_start = 1'b1;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_done) begin
               state_in = ST_ROOTS;
            end
         end
         ST_ROOTS: begin
            dn_in    = den_a[UW-1:0];
            n0_in    = num0_a[UW-1:0];
            n1_in    = num1_a[UW-1:0];
            v0_in    = (den_a != '0) && !num0_a[NW-1] && (num0_a <= den_a);
            v1_in    = (ent_ff.kind != KIND_LIN) && (den_a != '0) && !num1_a[NW-1] &&
                       (num1_a <= den_a);
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            dv_start = 1'b1;
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (dv_done0 && dv_done1) begin
               sel_in   = 1'b0;
               state_in = ST_EW;
            end
         end
         ST_EW: begin
            w0_in    = pw0[FRAC_BITS +: TW];
            w1_in    = pw1[FRAC_BITS-1 +: TW];
            w2_in    = pw2[FRAC_BITS +: TW];
            state_in = ST_EX;
         end
         ST_EX: begin
            x0_in    = $signed({1'b0, w0_ff}) * $signed(ent_ff.sx);
            x1_in    = $signed({1'b0, w1_ff}) * $signed(ent_ff.cx);
            x2_in    = $signed({1'b0, w2_ff}) * $signed(ent_ff.ex);
            state_in = ST_ES;
         end
         ST_ES: begin
            hits_in = hits_ff + 2'(hit);
            if (sel_ff) begin
               state_in = ST_DONE;
            end else begin
               sel_in   = 1'b1;
               state_in = ST_EW;
            end
         end
         ST_DONE: begin
            if (!stall) begin
               if (ent_ff.last) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.inside_res = tot_new[0];
                  rsp_data_in.crossings  = tot_new;
                  total_in               = '0;
               end else begin
                  total_in = tot_new;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hits_ff      <= 2'd0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         hits_ff      <= hits_in;
      end
      ent_ff      <= ent_in;
      rsp_data_ff <= rsp_data_in;
      prod0_ff    <= prod0_in;
      prod1_ff    <= prod1_in;
      sel_ff      <= sel_in;
      v0_ff       <= v0_in;
      v1_ff       <= v1_in;
      n0_ff       <= n0_in;
      n1_ff       <= n1_in;
      dn_ff       <= dn_in;
      w0_ff       <= w0_in;
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      x2_ff       <= x2_in;
   end

   // An edge crosses the ray at most twice.
   a_hits_bound: assert property (@(posedge clock) disable iff (reset)
      hits_ff != 2'd3)
      else $error("edge hit count out of range");

   // Finishing the last edge posts a result and starts the next path from zero.
   a_path_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && ent_ff.last && !stall) |=> (rsp_valid_ff && total_ff == '0))
      else $error("path total not cleared after result");

   // The even-odd flag is the parity of the posted count.
   a_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.inside_res == rsp_data_ff.crossings[0]))
      else $error("inside flag disagrees with crossing count");

   // The dividers are only started once the root operands are settled.
   a_div_order: assert property (@(posedge clock) disable iff (reset)
      dv_start |-> $past(state_ff == ST_ROOTS))
      else $error("divider started without root operands");
endmodule
`default_nettype wire

/* hdl/point_in_quadratic_path.sv */
// Each edge request is queued and then solved by a back that holds one edge at a time, so
// a queued edge waits until the back has finished the one before it. Edges settled by
// classification go straight to the path total, sloped straight edges take a multiply
// and a compare, curves linear in y skip the square root, and curves are paced by the
// square root (one root bit per cycle) and two parallel dividers (one quotient bit per cycle).
// Synchronous active-high reset empties the queue, drops any pending result, clears the total.
`default_nettype none
module point_in_quadratic_path (
   input logic       clock,
   input logic       reset,
   pqp_req_if.sink   req_chan,
   pqp_rsp_if.source rsp_chan
);
   import pqp_pkg::*;

   // The front classifies every request in the cycle it arrives: edges that
   // cannot cross the ray, or whose crossing is obvious, are tagged so the
   // back can retire them at once. Everything else carries the differences or
   // curve coefficients the back needs.
   logic     fifo_push, fifo_pop, fifo_full, fifo_empty;
   edge_type fifo_wr, fifo_rd;

   pqp_front u_front (
      .req_chan  (req_chan),
      .fifo_full (fifo_full),
      .fifo_push (fifo_push),
      .fifo_data (fifo_wr)
   );

   // A short queue decouples the front from the back, so new requests are
   // taken while a long curve evaluation or a stalled result holds the back.
   pqp_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (fifo_push),
      .wr_data (fifo_wr),
      .pop     (fifo_pop),
      .rd_data (fifo_rd),
      .full    (fifo_full),
      .empty   (fifo_empty)
   );

   // The back solves each edge for its ray crossings, keeps the saturating
   // total for the path and posts the result into an output register on the
   // last edge of the path.
   pqp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_data  (fifo_rd),
      .fifo_pop   (fifo_pop),
      .rsp_chan   (rsp_chan)
   );
endmodule
`default_nettype wire

/* tb/sv/pqp_path_checker.sv */
module pqp_path_checker
   import pqp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   output int          fail_count,
   output int          pending,
   output int          edges_seen,
   output int          paths_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE_Q = longint'(1) << FRAC_BITS;

   rsp_type           path_results[$];
   logic [CNT_BITS:0] path_total;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // One candidate curve parameter num/den; it counts when the curve point
   // at that parameter lies at or right of the test point.
   function automatic int root_crosses(input longint num, input longint den, input longint sx,
                                       input longint cx, input longint ex, input longint px);
      longint t;
      longint dt;
      longint x;
      if (den == 0) return 0;
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      if (num < 0 || num > den) return 0;
      t = (num << FRAC_BITS) / den;
      if (t > ONE_Q) t = ONE_Q;
      dt = ONE_Q - t;
      x = ((dt * dt) >>> FRAC_BITS) * sx + ((2 * dt * t) >>> FRAC_BITS) * cx
          + ((t * t) >>> FRAC_BITS) * ex;
      return (x >= px * ONE_Q) ? 1 : 0;
   endfunction

   function automatic int edge_crossings(input req_type r);
      longint px, py, sx, sy, cx, cy, ex, ey;
      longint dy, lhs, qa, qb, qc, disc, s;
      px = r.point_x; py = r.point_y;
      sx = r.start_x; sy = r.start_y;
      cx = r.ctrl_x;  cy = r.ctrl_y;
      ex = r.stop_x;  ey = r.stop_y;
      // The stop vertex on the ray's row belongs to the next edge.
      if (py == ey && px < ex) return 0;
      if (r.straight) begin
         if (py < ((sy < ey) ? sy : ey) || py > ((sy < ey) ? ey : sy)) return 0;
         if (sy == ey) return (((sx > ex) ? sx : ex) >= px) ? 1 : 0;
         dy = ey - sy;
         lhs = (sx - px) * dy + (ex - sx) * (py - sy);
         return ((dy > 0) ? (lhs >= 0) : (lhs <= 0)) ? 1 : 0;
      end
      qa = sy - 2 * cy + ey;
      qb = 2 * cy - 2 * sy;
      qc = sy - py;
      if (qa == 0) begin
         if (qb == 0) return 0;
         return root_crosses(-qc, qb, sx, cx, ex, px);
      end
      disc = qb * qb - 4 * qa * qc;
      if (disc < 0) return 0;
      s = longint'(int_sqrt(disc));
      return root_crosses(-qb + s, 2 * qa, sx, cx, ex, px)
           + root_crosses(-qb - s, 2 * qa, sx, cx, ex, px);
   endfunction

   assign pending = path_results.size();

   always @(posedge clock) begin
      rsp_type want;
      logic [CNT_BITS:0] sum;
      int errs;
      errs = 0;
      if (reset) begin
         path_total <= '0;
         fail_count <= 0;
         edges_seen <= 0;
         paths_seen <= 0;
      end else begin
         if (req_valid && req_ready) begin
            edges_seen <= edges_seen + 1;
            sum = path_total + (CNT_BITS+1)'(edge_crossings(req_data));
            if (sum > {1'b0, CNT_MAX}) sum = {1'b0, CNT_MAX};
            if (req_data.last_edge) begin
               want.crossings = sum[CNT_BITS-1:0];
               want.inside_res = sum[0];
               path_results.push_back(want);
               path_total <= '0;
            end else begin
               path_total <= sum;
            end
         end
         if (rsp_valid && rsp_ready) begin
            paths_seen <= paths_seen + 1;
            if (path_results.size() == 0) begin
               $display("%0t: unexpected result inside=%0b crossings=%0d", $time,
                        rsp_data.inside_res, rsp_data.crossings);
               errs++;
            end else begin
               want = path_results.pop_front();
               if (want.crossings !== rsp_data.crossings) begin
                  $display("%0t: crossings expected %0d actual %0d", $time,
                           want.crossings, rsp_data.crossings);
                  errs++;
               end
               if (want.inside_res !== rsp_data.inside_res) begin
                  $display("%0t: inside_res expected %0b actual %0b", $time,
                           want.inside_res, rsp_data.inside_res);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

/* tb/sv/tb.sv */
module tb;
   import pqp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     RANDOM_EDGES = 1630;
   localparam longint CYCLE_LIMIT  = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pqp_req_if req_if();
   pqp_rsp_if rsp_if();

   int     fail_count, pending, edges_seen, paths_seen;
   longint cycle_count = 0;
   // No idling on either side while this is set.
   logic   quiet = 1'b0;
   // Asks the receiver for its single long hold-off.
   logic   hold_go = 1'b0;

   always #2 clock = ~clock;

   point_in_quadratic_path dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   pqp_path_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_data   (req_if.data),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_data   (rsp_if.data),
      .fail_count (fail_count),
      .pending    (pending),
      .edges_seen (edges_seen),
      .paths_seen (paths_seen)
   );

   // The watchdog ends a run that hangs, well beyond the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("point_in_quadratic_path verification failed");
         $finish;
      end
   end

   // The receiver stalls in about a quarter of the cycles. Once, on request, it
   // holds off for a long stretch so the block fills and stalls its input.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         rsp_if.ready <= quiet || ($urandom_range(99) >= 26);
      end
   end

   function automatic req_type make_edge(input int px, input int py, input int sx,
                                         input int sy, input int cx, input int cy,
                                         input int ex, input int ey, input bit line,
                                         input bit last);
      req_type r;
      r.point_x = COORD_BITS'(px); r.point_y = COORD_BITS'(py);
      r.start_x = COORD_BITS'(sx); r.start_y = COORD_BITS'(sy);
      r.ctrl_x = COORD_BITS'(cx);  r.ctrl_y = COORD_BITS'(cy);
      r.stop_x = COORD_BITS'(ex);  r.stop_y = COORD_BITS'(ey);
      r.straight = line;
      r.last_edge = last;
      return r;
   endfunction

   // A coordinate around the center, now and then pinned to a range extreme.
   function automatic int pick_coord(input int center, input int span);
      int v;
      case ($urandom_range(19))
         0: v = -524288;
         1: v = 524287;
         default: v = center + $urandom_range(2 * span) - span;
      endcase
      return v;
   endfunction

   // Offers one request, idling first at random unless told not to.
   task automatic send_request(input req_type r);
      while (!quiet && $urandom_range(99) < 26) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // A closed path of random edges around a test point. Some vertices sit on
   // the ray's row so the vertex rule is exercised from both sides.
   task automatic send_path();
      int n, span, px, py, i, j;
      int vx[8];
      int vy[8];
      n = $urandom_range(2, 8);
      case ($urandom_range(3))
         0: span = 8;
         1: span = 300;
         2: span = 40000;
         default: span = 500000;
      endcase
      px = $urandom_range(2 * span) - span;
      py = $urandom_range(2 * span) - span;
      for (i = 0; i < n; i++) begin
         vx[i] = pick_coord(px, span);
         vy[i] = ($urandom_range(4) == 0) ? py : pick_coord(py, span);
      end
      for (i = 0; i < n; i++) begin
         j = (i + 1) % n;
         send_request(make_edge(px, py, vx[i], vy[i], pick_coord(px, span),
                                pick_coord(py, span), vx[j], vy[j],
                                1'($urandom_range(1)), i == n - 1));
      end
   endtask

   initial begin
      req_type r;
      int sent;
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed edges, one path each unless noted.
      // Sloped straight edge crossing right of the point, and one left of it.
      send_request(make_edge(0, 0, 10, -10, 0, 0, 20, 10, 1, 1));
      send_request(make_edge(0, 0, -10, -10, 0, 0, -20, 10, 1, 1));
      // Horizontal edges on the ray's row, reaching the point and falling short.
      send_request(make_edge(5, 7, 5, 7, 0, 0, 2, 7, 1, 1));
      send_request(make_edge(5, 7, 1, 7, 0, 0, 4, 7, 1, 1));
      // Stop vertex on the row right of the point, straight and curved.
      send_request(make_edge(0, 3, 10, -5, 0, 0, 10, 3, 1, 1));
      send_request(make_edge(0, 3, 10, -5, 30, 9, 10, 3, 0, 1));
      // Curve degenerating to a line in y, and one with a level tangent in y at its start.
      send_request(make_edge(0, 5, 10, 0, 12, 10, 14, 20, 0, 1));
      send_request(make_edge(0, 5, 10, 5, 12, 5, 14, 6, 0, 1));
      // Curve that never reaches the row.
      send_request(make_edge(0, 50, 10, 0, 12, 10, 14, 0, 0, 1));
      // Curve touching the row at its apex: a double root.
      send_request(make_edge(0, 5, 10, 0, 10, 10, 10, 0, 0, 1));
      // Curve with two distinct roots, and one whose root falls outside [0, 1].
      send_request(make_edge(0, 3, 10, 0, 20, 10, 30, 0, 0, 1));
      send_request(make_edge(0, 500, 10, 0, 20, 10, 30, 20, 0, 1));
      // Range extremes in every coordinate.
      send_request(make_edge(-524288, -524288, -524288, -524288, -524288, -524288,
                             -524288, -524288, 0, 1));
      send_request(make_edge(524287, 524287, 524287, 524287, 524287, 524287,
                             524287, 524287, 1, 1));
      send_request(make_edge(-524288, 0, 524287, -524288, -524288, 524287,
                             524287, 524287, 0, 1));
      send_request(make_edge(-524288, 0, 524287, 524287, 524287, -524288,
                             524287, -524288, 0, 1));
      // A square around the point: crossings accumulate over the path's edges, inside.
      send_request(make_edge(0, 0, -10, -10, 0, 0, 10, -10, 1, 0));
      send_request(make_edge(0, 0, 10, -10, 0, 0, 10, 10, 1, 0));
      send_request(make_edge(0, 0, 10, 10, 0, 0, -10, 10, 1, 0));
      send_request(make_edge(0, 0, -10, 10, 0, 0, -10, -10, 1, 1));
      wait_drained();

      // Mostly well-formed random paths, with some full-range noise in between.
      sent = 0;
      while (sent < RANDOM_EDGES) begin
         if (sent > 600 && sent < 800) quiet = 1'b1;
         else quiet = 1'b0;
         if (sent > 1000 && sent < 1010) hold_go = 1'b1;
         if (sent > 1300 && sent < 1310) wait_drained();
         if ($urandom_range(99) < 85) begin
            send_path();
            sent = edges_seen - 20;
         end else begin
            r = ($bits(req_type))'({$urandom, $urandom, $urandom, $urandom, $urandom});
            r.last_edge = ($urandom_range(3) == 0);
            send_request(r);
            sent++;
         end
      end
      quiet = 1'b0;
      wait_drained();
      repeat (120) @(posedge clock);

      $display("Checked %0d edge requests and %0d path results, with directed corner cases,",
               edges_seen, paths_seen);
      $display("back-pressure stalls and random idling on both channels.");
      if (fail_count == 0 && pending == 0) begin
         $display("point_in_quadratic_path verification clean");
      end else begin
         $display("point_in_quadratic_path verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/pqp_pkg.sv
hdl/pqp_req_if.sv
hdl/pqp_rsp_if.sv
hdl/pqp_front.sv
hdl/pqp_fifo.sv
hdl/pqp_isqrt.sv
hdl/pqp_div.sv
hdl/pqp_back.sv
hdl/point_in_quadratic_path.sv
tb/sv/pqp_path_checker.sv
tb/sv/tb.sv
